@@ sv/stack_engine_with_dup_swap_macros.svh @@
// ----------------------------------------------------------------------------
// Stack engine assertion macros
// Concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef STACK_ENGINE_WITH_DUP_SWAP_MACROS_SVH
`define STACK_ENGINE_WITH_DUP_SWAP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define STK_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("stack engine: same-cycle check failed");

`define STK_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("stack engine: next-cycle check failed");

`else

`define STK_ASSERT_NOW(label, clk, rstn, ante, cons)

`define STK_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

@@ sv/stk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack engine package
// Sizes, opcode and status codes, and the result record of the stack engine.
// ----------------------------------------------------------------------------
package stk_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_TOP   = 3'd2,
        OP_DUP   = 3'd3,
        OP_SWAP  = 3'd4,
        OP_CLEAR = 3'd5,
        OP_DUMP  = 3'd6
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NEED_TWO = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        status_t                  status;
        logic [CNT_W-1:0]         depth;
        logic                     empty;
        logic                     full;
        logic                     has_two;
        logic                     err;
        logic                     last;
    } result_t;

endpackage

@@ sv/stk_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack entry RAM
// One write port and one read port, read data registered and held between
// reads.
// ----------------------------------------------------------------------------
module stk_ram #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/stk_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack engine sequencer
// Decodes each opcode, runs the RAM read-modify-write steps, keeps the fill
// level and error latch, and holds the result register.
// ----------------------------------------------------------------------------
`include "stack_engine_with_dup_swap_macros.svh"

module stk_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [stk_pkg::OP_W-1:0]          in_opcode,
    input  logic signed [stk_pkg::DATA_W-1:0] in_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output stk_pkg::result_t                  out_res,
    output logic                              ram_we,
    output logic [stk_pkg::ADDR_W-1:0]        ram_waddr,
    output logic [stk_pkg::DATA_W-1:0]        ram_wdata,
    output logic                              ram_re,
    output logic [stk_pkg::ADDR_W-1:0]        ram_raddr,
    input  logic [stk_pkg::DATA_W-1:0]        ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DUP,
        S_SWAP_A,
        S_SWAP_B,
        S_SWAP_C,
        S_DUMP
    } state_t;

    state_t                       state_reg, state_next;
    logic [stk_pkg::CNT_W-1:0]    fill_reg, fill_next;
    logic                         err_reg, err_next;
    logic [stk_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic [stk_pkg::DATA_W-1:0]   hold_reg, hold_next;
    logic                         pop_reg, pop_next;
    logic                         valid_reg, valid_next;
    stk_pkg::result_t             res_reg, res_next;

    logic                         out_free;
    logic                         accept;
    logic                         emit;
    logic [stk_pkg::DATA_W-1:0]   e_value;
    stk_pkg::status_t             e_status;
    logic                         e_last;
    logic [stk_pkg::CNT_W-1:0]    top_cnt;
    logic [stk_pkg::CNT_W-1:0]    second_cnt;
    logic [stk_pkg::CNT_W-1:0]    idx_inc;
    logic [stk_pkg::ADDR_W-1:0]   top_addr;
    logic [stk_pkg::ADDR_W-1:0]   second_addr;
    logic [stk_pkg::ADDR_W-1:0]   fill_addr;
    logic                         is_empty;
    logic                         is_full;
    logic                         has_two;

    assign out_free    = !valid_reg || out_ready;
    assign in_ready    = (state_reg == S_IDLE) && out_free;
    assign accept      = in_valid && in_ready;
    assign top_cnt     = fill_reg - stk_pkg::CNT_W'(1);
    assign second_cnt  = fill_reg - stk_pkg::CNT_W'(2);
    assign idx_inc     = idx_reg + stk_pkg::CNT_W'(1);
    assign top_addr    = top_cnt[stk_pkg::ADDR_W-1:0];
    assign second_addr = second_cnt[stk_pkg::ADDR_W-1:0];
    assign fill_addr   = fill_reg[stk_pkg::ADDR_W-1:0];
    assign is_empty    = (fill_reg == '0);
    assign is_full     = (fill_reg >= stk_pkg::CNT_W'(stk_pkg::DEPTH));
    assign has_two     = (fill_reg >= stk_pkg::CNT_W'(2));

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        err_next   = err_reg;
        idx_next   = idx_reg;
        hold_next  = hold_reg;
        pop_next   = pop_reg;
        ram_we     = 1'b0;
        ram_waddr  = fill_addr;
        ram_wdata  = in_value;
        ram_re     = 1'b0;
        ram_raddr  = top_addr;
        emit       = 1'b0;
        e_value    = '0;
        e_status   = stk_pkg::ST_OK;
        e_last     = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_opcode) inside
                        stk_pkg::OP_PUSH: begin
                            emit = 1'b1;
                            if (is_full) begin
                                e_status = stk_pkg::ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + stk_pkg::CNT_W'(1);
                                e_value   = in_value;
                            end
                        end
                        stk_pkg::OP_POP, stk_pkg::OP_TOP: begin
                            if (is_empty) begin
                                emit     = 1'b1;
                                err_next = 1'b1;
                                e_value  = stk_pkg::DATA_W'(1);
                                e_status = stk_pkg::ST_EMPTY;
                            end else begin
                                ram_re     = 1'b1;
                                pop_next   = (in_opcode == stk_pkg::OP_POP);
                                state_next = S_READ;
                            end
                        end
                        stk_pkg::OP_DUP: begin
                            if (is_empty) begin
                                emit     = 1'b1;
                                e_status = stk_pkg::ST_EMPTY;
                            end else if (is_full) begin
                                emit     = 1'b1;
                                e_status = stk_pkg::ST_FULL;
                            end else begin
                                ram_re     = 1'b1;
                                state_next = S_DUP;
                            end
                        end
                        stk_pkg::OP_SWAP: begin
                            if (!has_two) begin
                                emit     = 1'b1;
                                e_status = stk_pkg::ST_NEED_TWO;
                            end else begin
                                ram_re     = 1'b1;
                                state_next = S_SWAP_A;
                            end
                        end
                        stk_pkg::OP_CLEAR: begin
                            emit      = 1'b1;
                            fill_next = '0;
                            err_next  = 1'b0;
                        end
                        stk_pkg::OP_DUMP: begin
                            if (!is_empty) begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                idx_next   = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_value = ram_rdata;
                    if (pop_reg) begin
                        fill_next = top_cnt;
                    end
                    state_next = S_IDLE;
                end
            end
            S_DUP: begin
                if (out_free) begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    fill_next  = fill_reg + stk_pkg::CNT_W'(1);
                    emit       = 1'b1;
                    e_value    = ram_rdata;
                    state_next = S_IDLE;
                end
            end
            S_SWAP_A: begin
                hold_next  = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = second_addr;
                state_next = S_SWAP_B;
            end
            S_SWAP_B: begin
                ram_we     = 1'b1;
                ram_waddr  = top_addr;
                ram_wdata  = ram_rdata;
                state_next = S_SWAP_C;
            end
            S_SWAP_C: begin
                if (out_free) begin
                    ram_we     = 1'b1;
                    ram_waddr  = second_addr;
                    ram_wdata  = hold_reg;
                    emit       = 1'b1;
                    e_value    = ram_rdata;
                    state_next = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_value = ram_rdata;
                    e_last  = (idx_inc == fill_reg);
                    if (e_last) begin
                        state_next = S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_inc[stk_pkg::ADDR_W-1:0];
                        idx_next  = idx_inc;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        res_next.value   = e_value;
        res_next.status  = e_status;
        res_next.depth   = fill_next;
        res_next.empty   = (fill_next == '0);
        res_next.full    = (fill_next >= stk_pkg::CNT_W'(stk_pkg::DEPTH));
        res_next.has_two = (fill_next >= stk_pkg::CNT_W'(2));
        res_next.err     = err_next;
        res_next.last    = e_last;

        if (emit) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            err_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            err_reg   <= err_next;
            valid_reg <= valid_next;
        end
        idx_reg  <= idx_next;
        hold_reg <= hold_next;
        pop_reg  <= pop_next;
        if (emit) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    `STK_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= stk_pkg::CNT_W'(stk_pkg::DEPTH))
    `STK_ASSERT_NOW(a_full_status, aclk, aresetn, emit && e_status == stk_pkg::ST_FULL, is_full)
    `STK_ASSERT_NOW(a_rw_apart, aclk, aresetn, ram_we && ram_re, ram_waddr != ram_raddr)
    `STK_ASSERT_NEXT(a_err_sticky, aclk, aresetn, err_reg && !(accept && in_opcode == stk_pkg::OP_CLEAR), err_reg)
    `STK_ASSERT_NOW(a_emit_room, aclk, aresetn, emit, out_free)

endmodule

@@ sv/stack_engine_with_dup_swap.sv @@
// Push, clear and error cases register a result at accept; pop, top and duplicate
// wait on the RAM read; swap does two reads and two writes on the single-write-port
// entry RAM. Dump gives its first entry after the RAM read, then one per cycle
// unless the receiver stalls; the RAM read port sets that pace. The next
// transaction is taken once the sequencer is idle and the result register is free.
// Reset clears fill level, error latch and result valid; entries stay undefined.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack engine with duplicate and swap
// Bounded LIFO of signed words driven by one opcode per transaction.
// ----------------------------------------------------------------------------
module stack_engine_with_dup_swap (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [stk_pkg::OP_W-1:0]          s_opcode,
    input  logic signed [stk_pkg::DATA_W-1:0] s_push_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [stk_pkg::DATA_W-1:0] m_result_value,
    output logic [stk_pkg::ST_W-1:0]          m_status,
    output logic [stk_pkg::CNT_W-1:0]         m_depth_count,
    output logic                              m_is_empty,
    output logic                              m_is_full,
    output logic                              m_has_two,
    output logic                              m_error_latched,
    output logic                              m_last_result
);

    stk_pkg::result_t             res;
    logic                         ram_we;
    logic [stk_pkg::ADDR_W-1:0]   ram_waddr;
    logic [stk_pkg::DATA_W-1:0]   ram_wdata;
    logic                         ram_re;
    logic [stk_pkg::ADDR_W-1:0]   ram_raddr;
    logic [stk_pkg::DATA_W-1:0]   ram_rdata;

    stk_ram #(
        .DEPTH  (stk_pkg::DEPTH),
        .DATA_W (stk_pkg::DATA_W),
        .ADDR_W (stk_pkg::ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stk_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_opcode (s_opcode),
        .in_value  (s_push_value),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    assign m_result_value  = res.value;
    assign m_status        = res.status;
    assign m_depth_count   = res.depth;
    assign m_is_empty      = res.empty;
    assign m_is_full       = res.full;
    assign m_has_two       = res.has_two;
    assign m_error_latched = res.err;
    assign m_last_result   = res.last;

endmodule

@@ sim/tb_stack_engine_with_dup_swap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack engine with duplicate and swap: testbench
// Drives opcodes through the input handshake with random gaps and receiver
// stalls. A stack model computes the expected result records per
// transaction, and every result is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_stack_engine_with_dup_swap;

    localparam logic [stk_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int unsigned MAX_REPORTS = 10;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic [stk_pkg::OP_W-1:0]          s_opcode;
    logic signed [stk_pkg::DATA_W-1:0] s_push_value;
    logic                              m_valid;
    logic                              m_ready;
    logic signed [stk_pkg::DATA_W-1:0] m_result_value;
    logic [stk_pkg::ST_W-1:0]          m_status;
    logic [stk_pkg::CNT_W-1:0]         m_depth_count;
    logic                              m_is_empty;
    logic                              m_is_full;
    logic                              m_has_two;
    logic                              m_error_latched;
    logic                              m_last_result;

    logic signed [stk_pkg::DATA_W-1:0] stk_words [stk_pkg::DEPTH];
    int unsigned                       stk_fill;
    logic                              stk_err;
    stk_pkg::result_t                  pending_results [$];

    int unsigned n_failures;
    int unsigned rx_hold_len;
    bit          tx_burst;
    bit          rx_burst;

    stack_engine_with_dup_swap dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_push_value    (s_push_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_value  (m_result_value),
        .m_status        (m_status),
        .m_depth_count   (m_depth_count),
        .m_is_empty      (m_is_empty),
        .m_is_full       (m_is_full),
        .m_has_two       (m_has_two),
        .m_error_latched (m_error_latched),
        .m_last_result   (m_last_result)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void expect_result(logic signed [stk_pkg::DATA_W-1:0] v,
                                          stk_pkg::status_t st, logic lst);
        stk_pkg::result_t r;
        r.value   = v;
        r.status  = st;
        r.depth   = stk_fill[stk_pkg::CNT_W-1:0];
        r.empty   = (stk_fill == 0);
        r.full    = (stk_fill >= stk_pkg::DEPTH);
        r.has_two = (stk_fill >= 2);
        r.err     = stk_err;
        r.last    = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void stack_apply(logic [stk_pkg::OP_W-1:0] op,
                                        logic signed [stk_pkg::DATA_W-1:0] val);
        logic signed [stk_pkg::DATA_W-1:0] t;
        case (op)
            stk_pkg::OP_PUSH: begin
                if (stk_fill >= stk_pkg::DEPTH) begin
                    expect_result('0, stk_pkg::ST_FULL, 1'b1);
                end else begin
                    stk_words[stk_fill] = val;
                    stk_fill++;
                    expect_result(val, stk_pkg::ST_OK, 1'b1);
                end
            end
            stk_pkg::OP_POP: begin
                if (stk_fill == 0) begin
                    stk_err = 1'b1;
                    expect_result(1, stk_pkg::ST_EMPTY, 1'b1);
                end else begin
                    stk_fill--;
                    expect_result(stk_words[stk_fill], stk_pkg::ST_OK, 1'b1);
                end
            end
            stk_pkg::OP_TOP: begin
                if (stk_fill == 0) begin
                    stk_err = 1'b1;
                    expect_result(1, stk_pkg::ST_EMPTY, 1'b1);
                end else begin
                    expect_result(stk_words[stk_fill-1], stk_pkg::ST_OK, 1'b1);
                end
            end
            stk_pkg::OP_DUP: begin
                if (stk_fill == 0) begin
                    expect_result('0, stk_pkg::ST_EMPTY, 1'b1);
                end else if (stk_fill >= stk_pkg::DEPTH) begin
                    expect_result('0, stk_pkg::ST_FULL, 1'b1);
                end else begin
                    t = stk_words[stk_fill-1];
                    stk_words[stk_fill] = t;
                    stk_fill++;
                    expect_result(t, stk_pkg::ST_OK, 1'b1);
                end
            end
            stk_pkg::OP_SWAP: begin
                if (stk_fill < 2) begin
                    expect_result('0, stk_pkg::ST_NEED_TWO, 1'b1);
                end else begin
                    t = stk_words[stk_fill-1];
                    stk_words[stk_fill-1] = stk_words[stk_fill-2];
                    stk_words[stk_fill-2] = t;
                    expect_result(stk_words[stk_fill-1], stk_pkg::ST_OK, 1'b1);
                end
            end
            stk_pkg::OP_CLEAR: begin
                stk_fill = 0;
                stk_err  = 1'b0;
                expect_result('0, stk_pkg::ST_OK, 1'b1);
            end
            stk_pkg::OP_DUMP: begin
                for (int unsigned i = 0; i < stk_fill; i++)
                    expect_result(stk_words[i], stk_pkg::ST_OK, i + 1 == stk_fill);
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [stk_pkg::DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // Enter and leave at a falling edge; valid stays up after acceptance.
    task automatic send_item(logic [stk_pkg::OP_W-1:0] op,
                             logic signed [stk_pkg::DATA_W-1:0] val);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_opcode     = op;
        s_push_value = val;
        do @(posedge aclk); while (!s_ready);
        stack_apply(op, val);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        stk_pkg::result_t got;
        stk_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.value   = m_result_value;
            got.status  = stk_pkg::status_t'(m_status);
            got.depth   = m_depth_count;
            got.empty   = m_is_empty;
            got.full    = m_is_full;
            got.has_two = m_has_two;
            got.err     = m_error_latched;
            got.last    = m_last_result;
            if (pending_results.size() == 0) begin
                n_failures++;
                if (n_failures <= MAX_REPORTS)
                    $display("unexpected result transaction: value=%0d status=%0d depth=%0d",
                             got.value, got.status, got.depth);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    n_failures++;
                    if (n_failures <= MAX_REPORTS) begin
                        $display("exp: v=%0d st=%0d d=%0d e=%b f=%b t=%b err=%b last=%b",
                                 want.value, want.status, want.depth, want.empty,
                                 want.full, want.has_two, want.err, want.last);
                        $display("got: v=%0d st=%0d d=%0d e=%b f=%b t=%b err=%b last=%b",
                                 got.value, got.status, got.depth, got.empty,
                                 got.full, got.has_two, got.err, got.last);
                    end
                end
            end
        end
    end

    initial begin
        int unsigned stall;
        int unsigned hold;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (rx_hold_len > 0) begin
                hold        = rx_hold_len;
                rx_hold_len = 0;
                m_ready     = 1'b0;
                repeat (hold) @(negedge aclk);
            end
            stall = rx_burst ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    task automatic test_empty_stack();
        send_item(stk_pkg::OP_POP, 32'sd5);
        send_item(stk_pkg::OP_TOP, 32'sd6);
        send_item(stk_pkg::OP_DUP, 32'sd7);
        send_item(stk_pkg::OP_SWAP, 32'sd8);
        send_item(stk_pkg::OP_DUMP, 32'sd9);
        send_item(OP_UNUSED, 32'sd10);
        send_item(stk_pkg::OP_CLEAR, 32'sd11);
        send_item(stk_pkg::OP_POP, -32'sd1);
    endtask

    task automatic test_small_stack();
        send_item(stk_pkg::OP_CLEAR, '0);
        send_item(stk_pkg::OP_PUSH, 32'sh7fffffff);
        send_item(stk_pkg::OP_SWAP, '0);
        send_item(stk_pkg::OP_TOP, '0);
        send_item(stk_pkg::OP_PUSH, 32'sh80000000);
        send_item(stk_pkg::OP_SWAP, '0);
        send_item(stk_pkg::OP_DUMP, '0);
        send_item(stk_pkg::OP_DUP, '0);
        send_item(OP_UNUSED, -32'sd1);
        send_item(stk_pkg::OP_POP, '0);
        send_item(stk_pkg::OP_PUSH, '0);
        send_item(stk_pkg::OP_PUSH, -32'sd1);
        send_item(stk_pkg::OP_DUMP, '0);
        send_item(stk_pkg::OP_CLEAR, '0);
    endtask

    task automatic test_fill_and_drain();
        send_item(stk_pkg::OP_CLEAR, '0);
        repeat (stk_pkg::DEPTH) send_item(stk_pkg::OP_PUSH, rand_word());
        send_item(stk_pkg::OP_PUSH, rand_word());
        send_item(stk_pkg::OP_DUP, '0);
        send_item(stk_pkg::OP_SWAP, '0);
        send_item(stk_pkg::OP_DUMP, '0);
        send_item(stk_pkg::OP_POP, '0);
        send_item(stk_pkg::OP_DUP, '0);
        send_item(stk_pkg::OP_TOP, '0);
        repeat (stk_pkg::DEPTH + 1) send_item(stk_pkg::OP_POP, '0);
        send_item(stk_pkg::OP_TOP, '0);
    endtask

    task automatic test_backpressure();
        wait_drained();
        tx_burst    = 1'b1;
        rx_hold_len = 300;
        send_item(stk_pkg::OP_CLEAR, '0);
        for (int i = 0; i < 30; i++)
            send_item((i % 6 == 5) ? stk_pkg::OP_DUMP : stk_pkg::OP_PUSH, rand_word());
        tx_burst = 1'b0;
        wait_drained();
    endtask

    task automatic test_random_mix(int unsigned n_items);
        int unsigned              sent;
        int unsigned              push_pct;
        logic [stk_pkg::OP_W-1:0] op;
        sent     = 0;
        push_pct = 50;
        while (sent < n_items) begin
            if (sent % 40 == 0) begin
                push_pct = $urandom_range(20, 80);
                tx_burst = ($urandom_range(0, 3) == 0);
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 99) < push_pct) begin
                op = stk_pkg::OP_PUSH;
            end else begin
                case ($urandom_range(0, 39))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 38, 39: op = stk_pkg::OP_POP;
                    10, 11, 12, 13, 14, 15:                op = stk_pkg::OP_TOP;
                    16, 17, 18, 19, 20, 21:                op = stk_pkg::OP_DUP;
                    22, 23, 24, 25, 26, 27, 28, 29:        op = stk_pkg::OP_SWAP;
                    30, 31:                                op = stk_pkg::OP_CLEAR;
                    32, 33, 34, 35, 36:                    op = stk_pkg::OP_DUMP;
                    default:                               op = OP_UNUSED;
                endcase
            end
            send_item(op, rand_word());
            if (op != OP_UNUSED)
                sent++;
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_opcode     = stk_pkg::OP_PUSH;
        s_push_value = '0;
        stk_fill     = 0;
        stk_err      = 1'b0;
        n_failures   = 0;
        rx_hold_len  = 0;
        tx_burst     = 1'b0;
        rx_burst     = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_empty_stack();
        test_small_stack();
        test_fill_and_drain();
        test_backpressure();
        test_random_mix(340);

        wait_drained();
        repeat (40) @(posedge aclk);
        if (n_failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
